// ----- rtl/core/mndst_pkg.sv -----
// Shared types and constants of the MIDI note delay slot table.
// Used by mndst_cell and midi_note_delay_slot_table; depends on nothing.
package mndst_pkg;

    localparam int SLOTS       = 32;
    localparam int MAX_RESULTS = 32;

    localparam int DELAY_W = 20;
    localparam int POS_W   = 16;
    localparam int DUE_W   = 21;
    localparam int MSG_W   = 22;
    localparam int STEP_W  = $clog2(SLOTS + 1);
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [STEP_W-1:0] STEP_FULL = STEP_W'(SLOTS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_RESULTS);

    // Input command codes
    localparam logic CMD_EVENT     = 1'b0;
    localparam logic CMD_BLOCK_END = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PASS   = 2'd0;
    localparam logic [1:0] KIND_NOTE   = 2'd1;
    localparam logic [1:0] KIND_MARKER = 2'd2;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INS   = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // One slot of the ring: message is {status, data_one, data_two}
    typedef struct packed {
        logic             used;
        logic [DUE_W-1:0] due;
        logic [MSG_W-1:0] msg;
    } slot_t;

endpackage

// ----- rtl/core/mndst_cell.sv -----
// One slot cell of the rotating slot ring.
// Depends on mndst_pkg for slot_t.
module mndst_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  mndst_pkg::slot_t din,
    output mndst_pkg::slot_t dout
);
    import mndst_pkg::*;

    logic             used_reg;
    logic [DUE_W-1:0] due_reg;
    logic [MSG_W-1:0] msg_reg;

    // Occupancy clears at reset; payload is meaningless while free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            used_reg <= din.used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            due_reg <= din.due;
            msg_reg <= din.msg;
        end
    end

    assign dout.used = used_reg;
    assign dout.due  = due_reg;
    assign dout.msg  = msg_reg;

endmodule

// ----- rtl/core/midi_note_delay_slot_table.sv -----
// Top level of the MIDI note delay slot table: sequencer, output staging
// and a ring of mndst_cell slots. Depends on mndst_pkg and mndst_cell.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser is the
//   command (event or end of block). A note-on/off event (status 0x80..0x9F)
//   is stored in the slot ring with due time sample_pos + delay_samples and
//   produces no result. Any other event comes straight back as one result.
//   An end-of-block item emits every stored note due within the block, in
//   ring order from the slot after the cursor, and ages every other note by
//   the block length; with nothing due it returns a single marker result.
//   m_tlast marks the final result of each input item.
//
// Ring operation:
//   The slots sit in a ring of cells rotating one slot per cycle while
//   inserting, and while scanning unless held; only the head cell is
//   examined and rewritten. The ring always rests with the slot after the
//   cursor at the head. Pass-through: pending, then output register.
//   Note insert: rotate past occupied slots, overwriting after a full turn.
//   End of block: one full turn of the ring, then the final flush.
//   One item is worked on at a time; s_tready is high only when idle.
//
// Reset and backpressure:
//   Reset frees every slot, clears the cursor and sets delay_samples to 0.
//   The output register and one pending result register decouple the ring
//   from m_tready; the ring holds its rotation only when a due note has to
//   go out while both are full.
module midi_note_delay_slot_table (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration: delay_samples
    input  logic                           cfg_we,
    input  logic [mndst_pkg::DELAY_W-1:0]  cfg_wdata,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: status_byte[7:0], data_one[14:8], data_two[21:15],
    //          sample_pos[37:22], block_len[53:38], zero fill[55:54]
    input  logic [55:0]                    s_tdata,
    // s_tuser: cmd[0]
    input  logic [0:0]                     s_tuser,
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: out_status[7:0], out_data_one[14:8], out_data_two[21:15],
    //          out_pos[37:22], zero fill[39:38]
    output logic [39:0]                    m_tdata,
    // m_tuser: kind[1:0]
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import mndst_pkg::*;

    // Input field split
    logic [7:0]       in_status;
    logic [6:0]       in_d1;
    logic [6:0]       in_d2;
    logic [POS_W-1:0] in_pos;
    logic [POS_W-1:0] in_blen;
    logic [MSG_W-1:0] in_msg;
    logic             in_note;

    assign in_status = s_tdata[7:0];
    assign in_d1     = s_tdata[14:8];
    assign in_d2     = s_tdata[21:15];
    assign in_pos    = s_tdata[37:22];
    assign in_blen   = s_tdata[53:38];
    assign in_msg    = {in_status, in_d1, in_d2};
    assign in_note   = (in_status[7:5] == 3'b100);

    // Registers
    logic [DELAY_W-1:0] delay_reg;
    logic [1:0]         state_reg,     state_next;
    logic [STEP_W-1:0]  step_reg,      step_next;
    logic [CNT_W-1:0]   cnt_reg,       cnt_next;
    logic [POS_W-1:0]   blen_reg,      blen_next;
    logic [DUE_W-1:0]   ins_due_reg,   ins_due_next;
    logic [MSG_W-1:0]   ins_msg_reg,   ins_msg_next;
    logic               pend_vld_reg,  pend_vld_next;
    logic [1:0]         pend_kind_reg, pend_kind_next;
    logic [MSG_W-1:0]   pend_msg_reg,  pend_msg_next;
    logic [POS_W-1:0]   pend_pos_reg,  pend_pos_next;
    logic               out_vld_reg,   out_vld_next;
    logic [1:0]         out_kind_reg,  out_kind_next;
    logic [MSG_W-1:0]   out_msg_reg,   out_msg_next;
    logic [POS_W-1:0]   out_pos_reg,   out_pos_next;
    logic               out_last_reg,  out_last_next;

    // Slot ring
    slot_t ring [SLOTS];
    slot_t head;
    slot_t tail_in;
    logic  shift_en;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_ring
            slot_t cell_in;
            if (gi == SLOTS - 1)
            begin : g_tail
                assign cell_in = tail_in;
            end
            else
            begin : g_mid
                assign cell_in = ring[gi + 1];
            end
            mndst_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .din      (cell_in),
                .dout     (ring[gi])
            );
        end
    endgenerate

    assign head = ring[0];

    logic out_free;
    logic hit;
    logic emit;

    assign out_free = !out_vld_reg || m_tready;
    assign hit      = head.used && (head.due < {{(DUE_W-POS_W){1'b0}}, blen_reg});
    assign emit     = hit && (cnt_reg < CNT_MAX);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        blen_next      = blen_reg;
        ins_due_next   = ins_due_reg;
        ins_msg_next   = ins_msg_reg;
        pend_vld_next  = pend_vld_reg;
        pend_kind_next = pend_kind_reg;
        pend_msg_next  = pend_msg_reg;
        pend_pos_next  = pend_pos_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_msg_next   = out_msg_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        shift_en       = 1'b0;
        tail_in        = head;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == CMD_BLOCK_END)
                    begin
                        blen_next  = in_blen;
                        step_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else if (in_note)
                    begin
                        ins_due_next = {{(DUE_W-POS_W){1'b0}}, in_pos}
                                     + {{(DUE_W-DELAY_W){1'b0}}, delay_reg};
                        ins_msg_next = in_msg;
                        step_next    = '0;
                        state_next   = ST_INS;
                    end
                    else
                    begin
                        pend_vld_next  = 1'b1;
                        pend_kind_next = KIND_PASS;
                        pend_msg_next  = in_msg;
                        pend_pos_next  = in_pos;
                        state_next     = ST_FLUSH;
                    end
                end
            end

            ST_INS:
            begin
                // Take the head slot if free, or overwrite it after a full turn
                shift_en = 1'b1;
                if (!head.used || step_reg == STEP_FULL)
                begin
                    tail_in.used = 1'b1;
                    tail_in.due  = ins_due_reg;
                    tail_in.msg  = ins_msg_reg;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            ST_SCAN:
            begin
                // Hold only when a due note meets a full pending and output stage
                if (!(emit && pend_vld_reg && !out_free))
                begin
                    shift_en = 1'b1;
                    if (emit)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next  = 1'b1;
                            out_kind_next = pend_kind_reg;
                            out_msg_next  = pend_msg_reg;
                            out_pos_next  = pend_pos_reg;
                            out_last_next = 1'b0;
                        end
                        pend_vld_next  = 1'b1;
                        pend_kind_next = KIND_NOTE;
                        pend_msg_next  = head.msg;
                        pend_pos_next  = head.due[POS_W-1:0];
                        cnt_next       = cnt_reg + 1'b1;
                        tail_in.used   = 1'b0;
                    end
                    else if (hit)
                    begin
                        tail_in.due = '0;
                    end
                    else if (head.used)
                    begin
                        tail_in.due = head.due - {{(DUE_W-POS_W){1'b0}}, blen_reg};
                    end
                    if (step_reg == STEP_LAST)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end

            ST_FLUSH:
            begin
                // Send the held result as the last one, or the empty marker
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_last_next = 1'b1;
                    if (pend_vld_reg)
                    begin
                        out_kind_next = pend_kind_reg;
                        out_msg_next  = pend_msg_reg;
                        out_pos_next  = pend_pos_reg;
                    end
                    else
                    begin
                        out_kind_next = KIND_MARKER;
                        out_msg_next  = '0;
                        out_pos_next  = '0;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= '0;
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                delay_reg <= cfg_wdata;
            end
            state_reg    <= state_next;
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        blen_reg      <= blen_next;
        ins_due_reg   <= ins_due_next;
        ins_msg_reg   <= ins_msg_next;
        pend_kind_reg <= pend_kind_next;
        pend_msg_reg  <= pend_msg_next;
        pend_pos_reg  <= pend_pos_next;
        out_kind_reg  <= out_kind_next;
        out_msg_reg   <= out_msg_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_pos_reg, out_msg_reg[6:0], out_msg_reg[13:7],
                       out_msg_reg[21:14]};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- test/note_delay_board_pkg.sv -----
// Scoreboard for the MIDI note delay slot table testbench: tracks the slot
// ring, predicts the result items of each accepted input item and checks them.
// Depends on mndst_pkg.
package note_delay_board_pkg;

    import mndst_pkg::*;

    localparam logic [7:0] NOTE_STATUS_LO = 8'h80;
    localparam logic [7:0] NOTE_STATUS_HI = 8'h9F;
    localparam int         REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       status;
        logic [6:0]       data_one;
        logic [6:0]       data_two;
        logic [POS_W-1:0] pos;
        logic             last;
    } note_result_t;

    class note_delay_board;

        bit                 slot_held   [SLOTS];
        logic [DUE_W-1:0]   slot_due_at [SLOTS];
        logic [MSG_W-1:0]   slot_msg    [SLOTS];
        int                 cursor_slot;
        logic [DELAY_W-1:0] note_delay;
        note_result_t       due_results [$];
        int                 mismatches;

        function new();
            foreach (slot_held[i])
                slot_held[i] = 1'b0;
            cursor_slot = 0;
            note_delay  = '0;
            mismatches  = 0;
        endfunction

        function void set_delay(logic [DELAY_W-1:0] value);
            note_delay = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function int next_slot(int s);
            return (s + 1 >= SLOTS) ? 0 : s + 1;
        endfunction

        function note_result_t make_result(logic [1:0] kind, logic [MSG_W-1:0] msg,
                                           logic [POS_W-1:0] pos, logic last);
            note_result_t r;
            r.kind     = kind;
            r.status   = msg[21:14];
            r.data_one = msg[13:7];
            r.data_two = msg[6:0];
            r.pos      = pos;
            r.last     = last;
            return r;
        endfunction

        // Note an accepted input item and queue the result items it causes.
        function void note_item(logic cmd, logic [55:0] tdata);
            logic [7:0]       status;
            logic [POS_W-1:0] pos;
            logic [POS_W-1:0] blen;
            logic [MSG_W-1:0] msg;
            int               s;
            bit               placed;
            bit               have_held;
            note_result_t     held;
            status    = tdata[7:0];
            pos       = tdata[37:22];
            blen      = tdata[53:38];
            msg       = {status, tdata[14:8], tdata[21:15]};
            have_held = 1'b0;
            held      = '0;
            if (cmd == CMD_EVENT) begin
                if (status >= NOTE_STATUS_LO && status <= NOTE_STATUS_HI) begin
                    // Take the first free slot after the cursor, else overwrite
                    s      = cursor_slot;
                    placed = 1'b0;
                    for (int i = 0; i < SLOTS && !placed; i++) begin
                        s = next_slot(s);
                        if (!slot_held[s])
                            placed = 1'b1;
                    end
                    if (!placed)
                        s = next_slot(cursor_slot);
                    cursor_slot    = s;
                    slot_held[s]   = 1'b1;
                    slot_due_at[s] = DUE_W'(pos) + DUE_W'(note_delay);
                    slot_msg[s]    = msg;
                end
                else begin
                    due_results.push_back(make_result(KIND_PASS, msg, pos, 1'b1));
                end
            end
            else begin
                // Scan the ring once from the slot after the cursor
                s = cursor_slot;
                for (int i = 0; i < SLOTS; i++) begin
                    s = next_slot(s);
                    if (slot_held[s]) begin
                        if (slot_due_at[s] < DUE_W'(blen)) begin
                            if (have_held)
                                due_results.push_back(held);
                            held = make_result(KIND_NOTE, slot_msg[s],
                                               slot_due_at[s][POS_W-1:0], 1'b0);
                            have_held    = 1'b1;
                            slot_held[s] = 1'b0;
                        end
                        else begin
                            slot_due_at[s] = slot_due_at[s] - DUE_W'(blen);
                        end
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    due_results.push_back(held);
                end
                else begin
                    due_results.push_back(make_result(KIND_MARKER, '0, '0, 1'b1));
                end
            end
        endfunction

        // Compare one accepted result item with the oldest expectation.
        function void check_result(logic [1:0] kind, logic [39:0] tdata, logic last);
            note_result_t want;
            note_result_t got;
            got = make_result(kind, {tdata[7:0], tdata[14:8], tdata[21:15]},
                              tdata[37:22], last);
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result item: kind %0d status %02h data %02h %02h",
                             got.kind, got.status, got.data_one, got.data_two,
                             " pos %0d last %0d", got.pos, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.status !== want.status ||
                got.data_one !== want.data_one || got.data_two !== want.data_two ||
                got.pos !== want.pos || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch: expected kind %0d status %02h data %02h %02h",
                             want.kind, want.status, want.data_one, want.data_two,
                             " pos %0d last %0d;", want.pos, want.last,
                             " got kind %0d status %02h data %02h %02h",
                             got.kind, got.status, got.data_one, got.data_two,
                             " pos %0d last %0d", got.pos, got.last);
            end
        endfunction

    endclass

endpackage

// ----- test/midi_note_delay_slot_table_tb.sv -----
// Testbench for midi_note_delay_slot_table: directed and random item streams
// under several idling patterns, checked by note_delay_board.
// Depends on mndst_pkg, note_delay_board_pkg and the block's RTL.
module midi_note_delay_slot_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mndst_pkg::*;
    import note_delay_board_pkg::*;

    // Cycles without any accepted item before the run is declared hung
    localparam int WATCHDOG_LIMIT = 5000;
    // Idle wait that lets the worst note insert finish before cfg is touched
    localparam int SETTLE_CYCLES  = SLOTS + 8;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [DELAY_W-1:0]  cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    // s_tdata: status_byte[7:0], data_one[14:8], data_two[21:15],
    //          sample_pos[37:22], block_len[53:38], zero fill[55:54]
    logic [55:0]         s_tdata;
    // s_tuser: cmd[0]
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // m_tdata: out_status[7:0], out_data_one[14:8], out_data_two[21:15],
    //          out_pos[37:22], zero fill[39:38]
    logic [39:0]         m_tdata;
    // m_tuser: kind[1:0]
    logic [1:0]          m_tuser;
    logic                m_tlast;

    note_delay_board     board;
    int                  send_idle_pct;
    int                  rx_stall_pct;
    int                  rx_hold_req;
    int                  items_accepted;

    midi_note_delay_slot_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [55:0] pack_item(logic [7:0] status, logic [6:0] d1,
                                              logic [6:0] d2, logic [15:0] pos,
                                              logic [15:0] blen);
        return {2'b00, blen, pos, d2, d1, status};
    endfunction

    function automatic logic [7:0] pick_note_status();
        return 8'($urandom_range(NOTE_STATUS_LO, NOTE_STATUS_HI));
    endfunction

    // Any status outside the note range: 0x00..0x7F or 0xA0..0xFF
    function automatic logic [7:0] pick_other_status();
        int s;
        s = $urandom_range(0, 223);
        return (s < 128) ? 8'(s) : 8'(s + 32);
    endfunction

    // Offer one item, idling first at the phase's rate; return at the
    // edge where it is accepted and hand it to the scoreboard.
    task automatic send_item(logic cmd, logic [55:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_item(cmd, data);
        items_accepted++;
    endtask

    task automatic send_event(logic [7:0] status, logic [6:0] d1, logic [6:0] d2,
                              logic [15:0] pos);
        send_item(CMD_EVENT, pack_item(status, d1, d2, pos, 16'($urandom)));
    endtask

    // Message fields and position are ignored on a block end; fill them with noise
    task automatic send_block_end(logic [15:0] blen);
        send_item(CMD_BLOCK_END, pack_item(8'($urandom), 7'($urandom), 7'($urandom),
                                           16'($urandom), blen));
    endtask

    // Drop valid, wait until every expected result has arrived, then let a
    // possible note insert finish inside the block.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Call only while the block is idle
    task automatic write_delay(logic [DELAY_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_delay(value);
    endtask

    // One audio block: a few events, mostly inside the block, then its end.
    // Now and then a long run of events, mostly notes, can overfill the ring.
    task automatic send_random_block();
        logic [15:0] blen;
        logic [15:0] pos;
        logic [7:0]  status;
        int          pick;
        int          n_events;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            blen = 16'd1;
        else if (pick < 20)
            blen = 16'hFFFF;
        else if (pick < 60)
            blen = 16'($urandom_range(1, 512));
        else
            blen = 16'($urandom_range(1, 65535));
        n_events = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40)
                                                 : $urandom_range(0, 6);
        repeat (n_events)
        begin
            // Mostly well-formed positions; some land past the block end
            pos    = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, blen - 1));
            status = ($urandom_range(0, 9) < 7) ? pick_note_status() : pick_other_status();
            send_event(status, 7'($urandom), 7'($urandom), pos);
        end
        send_block_end(blen);
    endtask

    task automatic run_phase(int send_pct, int rx_pct, logic [DELAY_W-1:0] dval,
                             int target);
        int start;
        settle();
        send_idle_pct = send_pct;
        rx_stall_pct  = rx_pct;
        write_delay(dval);
        start = items_accepted;
        while (items_accepted - start < target)
            send_random_block();
    endtask

    // Receiver: check each accepted result, then choose the next tready.
    // A requested hold keeps tready low while its count runs down.
    initial
    begin
        int hold_left;
        m_tready  = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tuser, m_tdata, m_tlast);
            if (hold_left == 0 && rx_hold_req != 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        send_idle_pct  = 0;
        rx_stall_pct   = 0;
        rx_hold_req    = 0;
        items_accepted = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: status bounds, field extremes, insert and drain by hand
        write_delay(20'd5);
        send_event(8'h00, 7'h00, 7'h00, 16'h0000);   // lowest pass-through
        send_event(8'hFF, 7'h7F, 7'h7F, 16'hFFFF);   // highest pass-through
        send_event(8'h7F, 7'h15, 7'h6A, 16'd3);      // just below the note range
        send_event(8'hA0, 7'h6A, 7'h15, 16'd4);      // just above the note range
        send_event(8'h80, 7'h3C, 7'h40, 16'd0);      // lowest note status, due 5
        send_event(8'h9F, 7'h7F, 7'h7F, 16'd10);     // highest note status, due 15
        send_event(8'h90, 7'h00, 7'h00, 16'd100);    // due 105
        send_block_end(16'd0);                       // zero length: marker, no aging
        send_block_end(16'd6);                       // emit first note at 5
        send_block_end(16'd10);                      // emit second note at 9
        send_block_end(16'hFFFF);                    // emit third note at 89
        send_block_end(16'd1);                       // empty ring: marker
        settle();
        write_delay(20'hFFFFF);
        send_event(8'h85, 7'h01, 7'h02, 16'hFFFF);   // widest due time
        send_event(8'h95, 7'h55, 7'h2A, 16'd0);
        send_block_end(16'hFFFF);                    // both age, marker

        // Random phases: no idling first
        run_phase(0, 0, 20'($urandom_range(0, 3000)), 40);

        // Pressure: hold the receiver off while the sender overfills the ring
        // and drains it; the block backs up and stalls its input.
        settle();
        write_delay(20'd0);
        rx_hold_req = 300;
        repeat (36)
            send_event(pick_note_status(), 7'($urandom), 7'($urandom),
                       16'($urandom_range(0, 200)));
        send_block_end(16'hFFFF);
        repeat (4)
            send_event(pick_other_status(), 7'($urandom), 7'($urandom), 16'($urandom));
        // Pause the sender until every result has come
        settle();

        run_phase(87, 0, 20'd0, 45);
        run_phase(0, 87, 20'hFFFFF, 45);
        run_phase(33, 33, 20'($urandom_range(0, 40000)), 50);

        settle();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
